// ----- design/rtc3_pkg.sv -----
// Shared types and constants for the three-wire serial clock-chip master.
package rtc3_pkg;

   localparam int BURST_BYTES_DEFAULT = 8;
   localparam int BYTE_CNT_W          = 5;
   localparam int BUF_DEPTH           = 8;
   localparam int BUF_IDX_W           = $clog2(BUF_DEPTH);
   localparam int QUEUE_DEPTH         = 2;
   localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

   // operation codes; request kinds reuse the start codes
   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_READ   = 3'd2;
   localparam logic [2:0] OP_BREAD  = 3'd3;
   localparam logic [2:0] OP_BWRITE = 3'd4;
   localparam logic [2:0] OP_LOAD   = 3'd5;

   localparam logic [7:0] CMD_BURST_READ  = 8'hBF;
   localparam logic [7:0] CMD_BURST_WRITE = 8'hBE;
   localparam logic [7:0] CMD_WPROT       = 8'h8E;
   localparam logic [7:0] WPROT_SET       = 8'h80;
   localparam logic [7:0] WPROT_CLEAR     = 8'h00;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_BEGIN,
      PH_CMD,
      PH_WDATA,
      PH_RDATA,
      PH_END
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TICK,
      KIND_START,
      KIND_LOAD,
      KIND_NOP
   } item_kind_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] address;
      logic [7:0] write_data;
      logic [2:0] byte_index;
      logic       sda_in;
   } req_payload_type;

   typedef struct packed {
      logic       sck;
      logic       sda_out;
      logic       sda_drive;
      logic       rst_pin;
      logic [7:0] read_data;
      logic [2:0] read_index;
      logic       read_valid;
      logic       busy_res;
      logic       done_res;
   } rsp_payload_type;

   typedef struct packed {
      item_kind_type kind;
      logic [2:0]    req_kind;
      logic [7:0]    address;
      logic [7:0]    write_data;
      logic [2:0]    byte_index;
      logic          sda_in;
   } queue_item_type;

endpackage

// ----- design/rtc3_front.sv -----
// Input side: decodes each transaction and holds it in a short queue for the sequencer.
module rtc3_front import rtc3_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            q_valid,
   input  logic            q_pop,
   output queue_item_type  q_item
);

   queue_item_type             q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]     count_ff, count_in;
   queue_item_type             item_dec;
   logic                       push;

   always_comb begin
      item_dec.req_kind   = req_data.operation;
      item_dec.address    = req_data.address;
      item_dec.write_data = req_data.write_data;
      item_dec.byte_index = req_data.byte_index;
      item_dec.sda_in     = req_data.sda_in;
      case (req_data.operation)
         OP_TICK:                                item_dec.kind = KIND_TICK;
         OP_WRITE, OP_READ, OP_BREAD, OP_BWRITE: item_dec.kind = KIND_START;
         OP_LOAD:                                item_dec.kind = KIND_LOAD;
         default:                                item_dec.kind = KIND_NOP;
      endcase
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign q_item    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_dec;
      end
   end

endmodule

// ----- design/rtc3_back.sv -----
// Pin sequencer: steps the frame one half bit per tick and registers each result.
module rtc3_back import rtc3_pkg::*; #(
   parameter int BURST_BYTES = BURST_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_valid,
   output logic            q_pop,
   input  queue_item_type  q_item,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             shift_ff, shift_in;
   logic [2:0]             bit_ff, bit_in;
   logic                   half_ff, half_in;
   logic [BYTE_CNT_W-1:0]  bcnt_ff, bcnt_in;
   logic [1:0]             frame_ff, frame_in;
   logic [2:0]             kind_ff, kind_in;
   logic [7:0]             addr_ff, addr_in;
   logic [7:0]             data_ff, data_in;
   logic                   sck_ff, sck_in;
   logic                   sda_ff, sda_in_r;
   logic                   drive_ff, drive_in;
   logic                   rst_ff, rst_in;
   logic [7:0]             buf_ff [BUF_DEPTH];
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_ff, rsp_in;

   logic                   tick_go, byte_end, more_w, more_r, is_read, more_frames;
   logic [BYTE_CNT_W:0]    bcnt_next;
   logic [BUF_IDX_W-1:0]   buf_raddr, buf_waddr;
   logic [7:0]             buf_rdata, buf_wdata, cmd_byte;
   logic                   buf_we;
   logic                   rv, dn;
   logic [7:0]             rd;
   logic [2:0]             ri;

   assign q_pop   = q_valid && (!rsp_valid_ff || rsp_ready);
   assign tick_go = q_pop && (q_item.kind == KIND_TICK) && (phase_ff != PH_IDLE);

   assign bcnt_next   = {1'b0, bcnt_ff} + 1'b1;
   assign byte_end    = half_ff && (bit_ff == 3'd7);
   assign is_read     = (kind_ff == OP_READ) || (kind_ff == OP_BREAD);
   assign more_w      = (kind_ff == OP_BWRITE) && (frame_ff == 2'd1)
                        && (bcnt_next < (BYTE_CNT_W+1)'(BURST_BYTES));
   assign more_r      = (kind_ff == OP_BREAD)
                        && (bcnt_next < (BYTE_CNT_W+1)'(BURST_BYTES));
   assign more_frames = (kind_ff == OP_BWRITE) && (frame_ff < 2'd2);

   // slot 0 feeds the first burst byte, later bytes come from the next slot
   assign buf_raddr = (phase_ff == PH_CMD) ? '0 : BUF_IDX_W'(bcnt_next);
   assign buf_rdata = buf_ff[buf_raddr];

   always_comb begin
      if (kind_ff == OP_BREAD) begin
         cmd_byte = CMD_BURST_READ;
      end else if (kind_ff == OP_BWRITE) begin
         cmd_byte = (frame_ff == 2'd1) ? CMD_BURST_WRITE : CMD_WPROT;
      end else begin
         cmd_byte = addr_ff;
      end
   end

   // next frame phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         case (q_item.kind)
            KIND_START: begin
               if (phase_ff == PH_IDLE) phase_in = PH_BEGIN;
            end
            KIND_TICK: begin
               case (phase_ff)
                  PH_IDLE:  phase_in = PH_IDLE;
                  PH_BEGIN: if (bit_ff == 3'd2) phase_in = PH_CMD;
                  PH_CMD:   if (byte_end) phase_in = is_read ? PH_RDATA : PH_WDATA;
                  PH_WDATA: if (byte_end && !more_w) phase_in = PH_END;
                  PH_RDATA: if (byte_end && !more_r) phase_in = PH_END;
                  PH_END: begin
                     if (bit_ff == 3'd4) phase_in = more_frames ? PH_BEGIN : PH_IDLE;
                  end
                  default:  phase_in = PH_IDLE;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // datapath, pins and result
   always_comb begin
      shift_in  = shift_ff;
      bit_in    = bit_ff;
      half_in   = half_ff;
      bcnt_in   = bcnt_ff;
      frame_in  = frame_ff;
      kind_in   = kind_ff;
      addr_in   = addr_ff;
      data_in   = data_ff;
      sck_in    = sck_ff;
      sda_in_r  = sda_ff;
      drive_in  = drive_ff;
      rst_in    = rst_ff;
      buf_we    = 1'b0;
      buf_waddr = q_item.byte_index;
      buf_wdata = q_item.write_data;
      rv        = 1'b0;
      dn        = 1'b0;
      rd        = '0;
      ri        = '0;

      if (q_pop && (q_item.kind == KIND_START) && (phase_ff == PH_IDLE)) begin
         kind_in  = q_item.req_kind;
         addr_in  = q_item.address;
         data_in  = q_item.write_data;
         frame_in = '0;
         bcnt_in  = '0;
         bit_in   = '0;
         half_in  = 1'b0;
         shift_in = '0;
      end

      if (q_pop && (q_item.kind == KIND_LOAD)) begin
         buf_we = 1'b1;
      end

      if (tick_go) begin
         case (phase_ff)
            PH_BEGIN: begin
               case (bit_ff)
                  3'd0:    rst_in = 1'b0;
                  3'd1:    sck_in = 1'b0;
                  default: rst_in = 1'b1;
               endcase
               if (bit_ff < 3'd2) begin
                  bit_in = bit_ff + 1'b1;
               end else begin
                  bit_in   = '0;
                  half_in  = 1'b0;
                  shift_in = cmd_byte;
               end
            end
            PH_CMD, PH_WDATA: begin
               if (!half_ff) begin
                  sck_in   = 1'b0;
                  drive_in = 1'b1;
                  sda_in_r = shift_ff[0];
                  shift_in = {1'b0, shift_ff[7:1]};
                  half_in  = 1'b1;
               end else begin
                  sck_in  = 1'b1;
                  half_in = 1'b0;
                  if (bit_ff != 3'd7) begin
                     bit_in = bit_ff + 1'b1;
                  end else begin
                     bit_in = '0;
                     if (phase_ff == PH_CMD) begin
                        bcnt_in = '0;
                        if (is_read) begin
                           shift_in = '0;
                        end else if (kind_ff == OP_WRITE) begin
                           shift_in = data_ff;
                        end else if (frame_ff == 2'd0) begin
                           shift_in = WPROT_CLEAR;
                        end else if (frame_ff == 2'd2) begin
                           shift_in = WPROT_SET;
                        end else begin
                           shift_in = buf_rdata;
                        end
                     end else if (more_w) begin
                        bcnt_in  = bcnt_next[BYTE_CNT_W-1:0];
                        shift_in = buf_rdata;
                     end
                  end
               end
            end
            PH_RDATA: begin
               if (!half_ff) begin
                  sck_in   = 1'b0;
                  drive_in = 1'b0;
                  shift_in = {q_item.sda_in, shift_ff[7:1]};
                  half_in  = 1'b1;
               end else begin
                  sck_in  = 1'b1;
                  half_in = 1'b0;
                  if (bit_ff != 3'd7) begin
                     bit_in = bit_ff + 1'b1;
                  end else begin
                     bit_in = '0;
                     rv     = 1'b1;
                     rd     = shift_ff;
                     if (kind_ff == OP_BREAD) begin
                        ri        = 3'(bcnt_ff[BUF_IDX_W-1:0]);
                        buf_we    = 1'b1;
                        buf_waddr = bcnt_ff[BUF_IDX_W-1:0];
                        buf_wdata = shift_ff;
                        if (more_r) begin
                           bcnt_in  = bcnt_next[BYTE_CNT_W-1:0];
                           shift_in = '0;
                        end
                     end
                  end
               end
            end
            PH_END: begin
               case (bit_ff)
                  3'd0: rst_in = 1'b0;
                  3'd1: sck_in = 1'b0;
                  3'd2: sck_in = 1'b1;
                  3'd3: begin
                     sda_in_r = 1'b0;
                     drive_in = 1'b1;
                  end
                  default: sda_in_r = 1'b1;
               endcase
               if (bit_ff < 3'd4) begin
                  bit_in = bit_ff + 1'b1;
               end else begin
                  bit_in = '0;
                  if (more_frames) begin
                     frame_in = frame_ff + 1'b1;
                  end else begin
                     dn = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      rsp_in.sck        = sck_in;
      rsp_in.sda_out    = sda_in_r;
      rsp_in.sda_drive  = drive_in;
      rsp_in.rst_pin    = rst_in;
      rsp_in.read_data  = rd;
      rsp_in.read_index = ri;
      rsp_in.read_valid = rv;
      rsp_in.busy_res   = (phase_in != PH_IDLE);
      rsp_in.done_res   = dn;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         shift_ff     <= '0;
         bit_ff       <= '0;
         half_ff      <= 1'b0;
         bcnt_ff      <= '0;
         frame_ff     <= '0;
         kind_ff      <= '0;
         addr_ff      <= '0;
         data_ff      <= '0;
         sck_ff       <= 1'b0;
         sda_ff       <= 1'b0;
         drive_ff     <= 1'b0;
         rst_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            shift_ff <= shift_in;
            bit_ff   <= bit_in;
            half_ff  <= half_in;
            bcnt_ff  <= bcnt_in;
            frame_ff <= frame_in;
            kind_ff  <= kind_in;
            addr_ff  <= addr_in;
            data_ff  <= data_in;
            sck_ff   <= sck_in;
            sda_ff   <= sda_in_r;
            drive_ff <= drive_in;
            rst_ff   <= rst_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_ff <= rsp_in;
      end
      if (buf_we) begin
         buf_ff[buf_waddr] <= buf_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/three_wire_rtc_serial_master_unit.sv -----
// Top level of the three-wire serial clock-chip master.
// Each transaction on req_ (a tick, a request, or a burst buffer load) yields exactly one
// transaction on rsp_ carrying the pin levels after that step plus any completed read byte.
// Transactions enter a two-entry queue, and the sequencer retires one per clock unless
// rsp_ready stalls a full result register, so the sustained rate is one transaction per
// cycle; an accepted request passes the queue entry and then the result register before
// rsp_valid rises. The sequencer step is combinational logic on the frame state.
// rsp_ready stalls only the back end, and the queue keeps taking new transactions until
// both entries are full; a full queue holds req_ready low until the count register shows
// a freed slot. BURST_BYTES (1 to 8, the burst buffer depth) sets the burst length.
module three_wire_rtc_serial_master_unit import rtc3_pkg::*; #(
   parameter int BURST_BYTES = BURST_BYTES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   logic           q_valid;
   logic           q_pop;
   queue_item_type q_item;

   rtc3_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item)
   );

   rtc3_back #(
      .BURST_BYTES (BURST_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // a finished request is never also reporting a read byte
   a_done_no_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.done_res && rsp_data.read_valid))
      else $error("done and read byte in the same result");

   // finishing a request leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("busy still set on completion");

   // a read byte completes on a clock-high step with the data line released
   a_read_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.read_valid) |-> (rsp_data.sck && !rsp_data.sda_drive))
      else $error("read byte completed with wrong pin state");

   // nothing is reported while no transaction was queued for the sequencer
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !q_valid) |=> !rsp_valid)
      else $error("result produced without a queued transaction");

endmodule
